// ===== rtl/tmtw_pkg.sv =====
// Shared types and constants of the text-mode terminal writer.
package tmtw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'd7;

  typedef struct packed {
    logic load;
    logic step;
  } tmtw_sweep_cmd_t;

endpackage

// ===== rtl/tmtw_ram.sv =====
// Single-port-write, single-port-read screen memory with registered read data.
module tmtw_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tmtw_sweep.sv =====
// Shared address unit: a loadable counter with an incrementer and an end-of-range compare.
module tmtw_sweep
  import tmtw_pkg::*;
#(
  parameter int AW          = 11,
  parameter int RESET_LIMIT = 1999
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tmtw_sweep_cmd_t cmd,
  input  logic [AW-1:0]   start_addr,
  input  logic [AW-1:0]   limit,
  output logic [AW-1:0]   addr,
  output logic            last
);

  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] limit_r, limit_nxt;

  always_comb begin
    addr_nxt  = addr_r;
    limit_nxt = limit_r;
    if (cmd.load) begin
      addr_nxt  = start_addr;
      limit_nxt = limit;
    end else if (cmd.step) begin
      addr_nxt = addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      limit_r <= AW'(RESET_LIMIT);
    end else begin
      addr_r  <= addr_nxt;
      limit_r <= limit_nxt;
    end
  end

  assign addr = addr_r;
  assign last = (addr_r == limit_r);

endmodule

// ===== rtl/text_mode_terminal_writer.sv =====
// Top level of the text-mode terminal writer: item sequencer, cursor and ports.
//
// A command word is taken at a clock edge with start high and busy low. Put
// (in_op 0) writes in_char_code at the cursor in the current colour, with
// newline, backspace and tab handled as cursor moves (backspace also blanks
// the cell it steps back onto); clear (in_op 1) blanks the screen and homes
// the cursor; read (in_op 2) returns one cell. Each word gives one result,
// shown for one cycle with out_strobe high; the receiver cannot hold it off.
// The colour is written through cfg_valid/cfg_ready and cfg_ready is always high.
// busy falls as the strobe rises, so the next word can be taken while the
// strobe is high. Scroll and clear are set by the single memory write port,
// one cell a cycle. After reset the screen memory is blanked to colour 7,
// one cell a cycle, and busy stays high until that pass ends.
module text_mode_terminal_writer
  import tmtw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_strobe,
  output logic [15:0] out_cell_entry,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_text_color
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_SCRPRE = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_CLEAR  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r;
  logic [7:0]    ch_r;
  logic [4:0]    rr_r;
  logic [6:0]    rc_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    color_r;
  logic          scrolled_r, scrolled_nxt;

  logic          out_strobe_r;
  logic [15:0]   out_cell_entry_r;
  logic [4:0]    out_cursor_row_r;
  logic [6:0]    out_cursor_col_r;
  logic          out_scrolled_r;

  logic          done;
  logic [15:0]   done_entry;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  tmtw_sweep_cmd_t sw_cmd;
  logic [AW-1:0]   sw_start, sw_limit, sw_addr;
  logic            sw_last;

  logic          accept;
  logic [AW-1:0] cur_addr, bs_addr, rd_addr;
  logic          rd_in_range;
  logic [CW:0]   inc_col, tab_col;
  logic          row_last;

  assign accept      = start && (state_r == S_IDLE);
  assign cur_addr    = AW'(int'(row_r) * COLS + int'(col_r));
  assign bs_addr     = AW'(int'(row_r) * COLS + int'(col_r) - 1);
  assign rd_in_range = (int'(rr_r) < ROWS) && (int'(rc_r) < COLS);
  assign rd_addr     = rd_in_range ? AW'(int'(rr_r) * COLS + int'(rc_r)) : '0;
  assign inc_col     = {1'b0, col_r} + (CW+1)'(1);
  assign tab_col     = ({1'b0, col_r} + (CW+1)'(4)) & ~(CW+1)'(3);
  assign row_last    = (row_r == RW'(ROWS - 1));

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    scrolled_nxt = scrolled_r;
    done         = 1'b0;
    done_entry   = 16'd0;
    ram_we       = 1'b0;
    ram_waddr    = sw_addr;
    ram_wdata    = {color_r, CH_SPACE};
    ram_re       = 1'b0;
    ram_raddr    = sw_addr + AW'(COLS);
    sw_cmd       = '0;
    sw_start     = '0;
    sw_limit     = AW'(DEPTH - 1);

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_COLOR, CH_SPACE};
        if (sw_last) begin
          state_nxt = S_IDLE;
        end else begin
          sw_cmd.step = 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          scrolled_nxt = 1'b0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_PUT: begin
            if (ch_r == CH_BACKSPACE) begin
              if (col_r != '0) begin
                col_nxt   = col_r - CW'(1);
                ram_we    = 1'b1;
                ram_waddr = bs_addr;
              end
              done = 1'b1;
            end else begin
              if (ch_r != CH_NEWLINE && ch_r != CH_TAB) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {color_r, ch_r};
              end
              if (ch_r == CH_NEWLINE ||
                  (ch_r == CH_TAB && tab_col >= (CW+1)'(COLS)) ||
                  (ch_r != CH_TAB && inc_col >= (CW+1)'(COLS))) begin
                col_nxt = '0;
                if (row_last) begin
                  scrolled_nxt = 1'b1;
                  sw_cmd.load  = 1'b1;
                  sw_limit     = AW'((ROWS - 1) * COLS - 1);
                  state_nxt    = S_SCRPRE;
                end else begin
                  row_nxt = row_r + RW'(1);
                  done    = 1'b1;
                end
              end else begin
                col_nxt = (ch_r == CH_TAB) ? tab_col[CW-1:0] : inc_col[CW-1:0];
                done    = 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            row_nxt     = '0;
            col_nxt     = '0;
            sw_cmd.load = 1'b1;
            state_nxt   = S_CLEAR;
          end
          OP_READ: begin
            ram_re    = 1'b1;
            ram_raddr = rd_addr;
            state_nxt = S_RDWAIT;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_RDWAIT: begin
        done       = 1'b1;
        done_entry = rd_in_range ? ram_rdata : 16'd0;
      end
      S_SCRPRE: begin
        ram_re    = 1'b1;
        state_nxt = S_SCROLL;
      end
      S_SCROLL: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (sw_last) begin
          sw_cmd.load = 1'b1;
          sw_start    = AW'((ROWS - 1) * COLS);
          state_nxt   = S_FILL;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = sw_addr + AW'(COLS + 1);
          sw_cmd.step = 1'b1;
        end
      end
      S_FILL, S_CLEAR: begin
        ram_we = 1'b1;
        if (sw_last) begin
          done = 1'b1;
        end else begin
          sw_cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      row_r        <= '0;
      col_r        <= '0;
      color_r      <= RESET_COLOR;
      scrolled_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      scrolled_r   <= scrolled_nxt;
      out_strobe_r <= done;
      if (cfg_valid) begin
        color_r <= cfg_text_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_col;
    end
    if (done) begin
      out_cell_entry_r <= done_entry;
      out_cursor_row_r <= 5'(row_nxt);
      out_cursor_col_r <= 7'(col_nxt);
      out_scrolled_r   <= scrolled_nxt;
    end
  end

  tmtw_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tmtw_sweep #(
    .AW         (AW),
    .RESET_LIMIT(DEPTH - 1)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (sw_cmd),
    .start_addr(sw_start),
    .limit     (sw_limit),
    .addr      (sw_addr),
    .last      (sw_last)
  );

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_strobe     = out_strobe_r;
  assign out_cell_entry = out_cell_entry_r;
  assign out_cursor_row = out_cursor_row_r;
  assign out_cursor_col = out_cursor_col_r;
  assign out_scrolled   = out_scrolled_r;

`ifndef NO_ASSERTIONS
  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result word held for more than one cycle");
  a_strobe_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result word shown while still busy");
  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (int'(out_cursor_col) < COLS)) else $error("cursor column out of range");
  a_scroll_home : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_scrolled) |-> (out_cursor_col == 7'd0 &&
      out_cursor_row == 5'(ROWS - 1))) else $error("scroll left cursor off the last row");
  a_port_clash : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr)) else $error("memory read and write clash");
`endif

endmodule
